/* rtl/core/ldr_pkg.sv */
// Shared types and constants for the longest distinct run block.
// Used by ldr_ctrl, ldr_datapath and longest_distinct_run. No dependencies.
package ldr_pkg;

	localparam int LDR_MAX_ITEMS = 1024;
	localparam int VAL_W         = 32;
	localparam int RUN_W         = 11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CMP,
		ST_COMMIT
	} ldr_state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // capture input item, scan index <= item count
		logic ovf_set;   // store full: flag overflow, item dropped
		logic rd_first;  // read entry scan-1
		logic rd_next;   // read entry scan-2 while stepping
		logic match;     // window restarts after matched entry
		logic step;      // scan index down by one
		logic commit;    // write value, bump count, update best
		logic emit;      // drive result, clear sequence state
	} ldr_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic full;           // item count reached capacity
		logic at_start;       // scan index equals window start
		logic next_at_start;  // scan index - 1 equals window start
		logic match;          // read entry equals held value
		logic last;           // held item closes the sequence
	} ldr_sts_t;

endpackage

/* rtl/core/longest_distinct_run.sv */
// Longest run of consecutive distinct values, top level. Depends on ldr_pkg, ldr_ctrl,
// ldr_datapath. Each item scans k stored entries (at most the window length, one store
// read per cycle); an item dropped on a full store is not scanned.
// One item at a time; busy is high after accept until the end of the item's work. Result
// strobe (done) comes in the cycle after the last item's work, held one cycle; the receiver
// cannot stall. Reset (arst_n low) clears all sequence state; the store is never cleared.
module longest_distinct_run
	import ldr_pkg::*;
#(
	parameter int MAX_ITEMS = LDR_MAX_ITEMS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// input transfer: start && !busy
	input  logic                    start,
	output logic                    busy,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last_item,
	// result transfer: done high for one cycle
	output logic                    done,
	output logic        [RUN_W-1:0] longest_run,
	output logic                    overflow
);

	ldr_cmd_t cmd;
	ldr_sts_t sts;

	// Controller: IDLE -> LOAD -> (CMP)* -> COMMIT -> IDLE.
	// LOAD drops the item when the store is full, or skips the scan on an
	// empty window. CMP compares one stored entry per cycle, newest first,
	// while the next read is already in flight.
	ldr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: value store, window start, best length, overflow flag and
	// the registered result. A match moves the window start just past the
	// matching entry; commit appends the value and updates the best length.
	// Only entries written in the current sequence are ever read.
	ldr_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.last_item   (last_item),
		.cmd         (cmd),
		.sts         (sts),
		.done        (done),
		.longest_run (longest_run),
		.overflow    (overflow)
	);

endmodule

/* rtl/core/ldr_ctrl.sv */
// Controller state machine for the longest distinct run block.
// Depends on ldr_pkg; drives ldr_datapath through ldr_cmd_t.
module ldr_ctrl
	import ldr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ldr_sts_t sts,
	output ldr_cmd_t cmd,
	output logic     busy
);

	ldr_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_nx = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.full) begin
					cmd.ovf_set = 1'b1;
					cmd.emit    = sts.last;
					state_nx    = ST_IDLE;
				end else if (sts.at_start) begin
					state_nx = ST_COMMIT;
				end else begin
					cmd.rd_first = 1'b1;
					state_nx     = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.match) begin
					cmd.match = 1'b1;
					state_nx  = ST_COMMIT;
				end else begin
					cmd.step = 1'b1;
					if (sts.next_at_start) begin
						state_nx = ST_COMMIT;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				cmd.emit   = sts.last;
				state_nx   = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/ldr_datapath.sv */
// Datapath for the longest distinct run block: value store, window registers,
// scan index and result registers. Depends on ldr_pkg.
module ldr_datapath
	import ldr_pkg::*;
#(
	parameter int MAX_ITEMS = LDR_MAX_ITEMS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last_item,
	input  ldr_cmd_t                cmd,
	output ldr_sts_t                sts,
	output logic                    done,
	output logic        [RUN_W-1:0] longest_run,
	output logic                    overflow
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);

	logic [VAL_W-1:0] store [MAX_ITEMS];
	logic [VAL_W-1:0] rdata_q;
	logic [VAL_W-1:0] value_q;
	logic             last_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    wstart_q;
	logic [CW-1:0]    best_q;
	logic             ovf_q;
	logic [CW-1:0]    scan_q;

	logic [CW-1:0]    scan_m1;
	logic [CW-1:0]    scan_m2;
	logic [CW-1:0]    rd_idx;
	logic [CW-1:0]    len;
	logic [CW-1:0]    best_nx;
	logic             ovf_nx;

	assign scan_m1 = scan_q - CW'(1);
	assign scan_m2 = scan_q - CW'(2);
	assign rd_idx  = cmd.rd_first ? scan_m1 : scan_m2;
	assign len     = count_q + CW'(1) - wstart_q;
	assign best_nx = (cmd.commit && (len > best_q)) ? len : best_q;
	assign ovf_nx  = ovf_q | cmd.ovf_set;

	assign sts.full          = (count_q == CW'(MAX_ITEMS));
	assign sts.at_start      = (scan_q == wstart_q);
	assign sts.next_at_start = (scan_m1 == wstart_q);
	assign sts.match         = (rdata_q == value_q);
	assign sts.last          = last_q;

	// single-port store, registered read
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			store[count_q[AW-1:0]] <= value_q;
		end
		if (cmd.rd_first || cmd.rd_next) begin
			rdata_q <= store[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			count_q     <= '0;
			wstart_q    <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			done        <= 1'b0;
			longest_run <= '0;
			overflow    <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (cmd.emit) begin
				longest_run <= RUN_W'(best_nx);
				overflow    <= ovf_nx;
			end
			if (cmd.load) begin
				last_q <= last_item;
				scan_q <= count_q;
			end else if (cmd.step) begin
				scan_q <= scan_m1;
			end
			if (cmd.emit) begin
				count_q  <= '0;
				wstart_q <= '0;
				best_q   <= '0;
				ovf_q    <= 1'b0;
			end else begin
				if (cmd.match) begin
					wstart_q <= scan_q;
				end
				if (cmd.commit) begin
					count_q <= count_q + CW'(1);
					best_q  <= best_nx;
				end
				ovf_q <= ovf_nx;
			end
		end
	end

endmodule
